@@ design/u8d_pkg.sv @@
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Holds the channel payload types, the job record that travels from the
// front end to the back end, and the UTF-8 decoding constants.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int CP_W        = 21;
   localparam int CNT_W       = 3;   // holds a result count of 1 to 4
   localparam int IDX_W       = 2;   // index of a result within one job
   localparam int JOB_DEPTH   = 4;

   localparam logic [CP_W-1:0] REPL_CP  = 21'h00FFFD;
   localparam logic [CP_W-1:0] MAX_CP   = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
   localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
   localparam logic [CP_W-1:0] MIN_CP2  = 21'h000080;
   localparam logic [CP_W-1:0] MIN_CP3  = 21'h000800;
   localparam logic [CP_W-1:0] MIN_CP4  = 21'h010000;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_2    = 3'd2;
   localparam logic [2:0] LEN_3    = 3'd3;
   localparam logic [2:0] LEN_4    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            malformed;
      logic            run_last;
      logic            stream_last;
   } rsp_type;

   // All results of one byte but the last are replacements; only the last
   // one needs its own code point and flag.
   typedef struct packed {
      logic [CNT_W-1:0] num_results;
      logic [CP_W-1:0]  last_cp;
      logic             last_mal;
      logic             stream_end;
   } job_type;

   function automatic logic [CP_W-1:0] min_cp(input logic [2:0] len);
      logic [CP_W-1:0] v;
      v = '0;
      unique case (len)
         LEN_2:   v = MIN_CP2;
         LEN_3:   v = MIN_CP3;
         LEN_4:   v = MIN_CP4;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

@@ design/u8d_front.sv @@
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and sequence state
// Tracks the open multi-byte sequence and turns each accepted byte into a
// job record that says how many results it causes.
// ----------------------------------------------------------------------------
module u8d_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  u8d_pkg::req_type req_data,
   output logic             job_valid,
   output u8d_pkg::job_type job
);
   import u8d_pkg::*;

   logic [2:0]      exp_ff, exp_in;
   logic [2:0]      seen_ff, seen_in;
   logic [CP_W-1:0] part_ff, part_in;

   logic [7:0]       b;
   logic             is_cont;
   logic [2:0]       seen_inc;
   logic [CP_W-1:0]  acc;
   logic             bad_val;
   logic [CNT_W-1:0] flush_cnt;
   logic             tail_v;
   logic             tail_mal;
   logic [CP_W-1:0]  tail_cp;
   logic [CNT_W-1:0] total;

   assign b        = req_data.data_byte;
   assign is_cont  = (b & CONT_MASK) == CONT_TAG;
   assign seen_inc = seen_ff + 3'd1;
   assign acc      = {part_ff[CP_W-7:0], b[5:0] & PAYLOAD_MASK[5:0]};
   assign bad_val  = (acc < min_cp(exp_ff)) || (acc > MAX_CP) ||
                     ((acc >= SURR_LO) && (acc <= SURR_HI));

   always_comb begin
      logic fresh;
      logic opened;
      fresh     = 1'b1;
      opened    = 1'b0;
      flush_cnt = '0;
      tail_v    = 1'b0;
      tail_mal  = 1'b0;
      tail_cp   = '0;
      exp_in    = exp_ff;
      seen_in   = seen_ff;
      part_in   = part_ff;

      if (exp_ff != LEN_NONE) begin
         if (is_cont) begin
            fresh = 1'b0;
            if (seen_inc >= exp_ff) begin
               exp_in  = LEN_NONE;
               seen_in = '0;
               part_in = '0;
               if (bad_val) begin
                  flush_cnt = seen_inc;
               end else begin
                  tail_v  = 1'b1;
                  tail_cp = acc;
               end
            end else if (req_data.stream_end) begin
               flush_cnt = seen_inc;
               exp_in    = LEN_NONE;
               seen_in   = '0;
               part_in   = '0;
            end else begin
               seen_in = seen_inc;
               part_in = acc;
            end
         end else begin
            // Interrupted sequence: flush it, then decode this byte afresh.
            flush_cnt = seen_ff;
            exp_in    = LEN_NONE;
            seen_in   = '0;
            part_in   = '0;
         end
      end

      if (fresh) begin
         priority if (!b[7]) begin
            tail_v  = 1'b1;
            tail_cp = {{(CP_W-8){1'b0}}, b};
         end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            opened  = 1'b1;
            exp_in  = LEN_2;
            seen_in = 3'd1;
            part_in = {{(CP_W-5){1'b0}}, b[4:0]};
         end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            opened  = 1'b1;
            exp_in  = LEN_3;
            seen_in = 3'd1;
            part_in = {{(CP_W-4){1'b0}}, b[3:0]};
         end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            opened  = 1'b1;
            exp_in  = LEN_4;
            seen_in = 3'd1;
            part_in = {{(CP_W-3){1'b0}}, b[2:0]};
         end else begin
            tail_v   = 1'b1;
            tail_mal = 1'b1;
            tail_cp  = REPL_CP;
         end
         if (opened && req_data.stream_end) begin
            tail_v   = 1'b1;
            tail_mal = 1'b1;
            tail_cp  = REPL_CP;
            exp_in   = LEN_NONE;
            seen_in  = '0;
            part_in  = '0;
         end
      end
   end

   assign total = flush_cnt + {{(CNT_W-1){1'b0}}, tail_v};

   assign job_valid       = accept && (total != '0);
   assign job.num_results = total;
   assign job.last_cp     = tail_v ? tail_cp : REPL_CP;
   assign job.last_mal    = tail_v ? tail_mal : 1'b1;
   assign job.stream_end  = req_data.stream_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_ff  <= LEN_NONE;
         seen_ff <= '0;
         part_ff <= '0;
      end else if (accept) begin
         exp_ff  <= exp_in;
         seen_ff <= seen_in;
         part_ff <= part_in;
      end
   end

endmodule

@@ design/u8d_job_fifo.sv @@
// ----------------------------------------------------------------------------
// u8d_job_fifo: short job queue between front and back end
// A register-based circular queue with a registered fill count.
// ----------------------------------------------------------------------------
module u8d_job_fifo #(
   parameter int Depth = u8d_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  u8d_pkg::job_type push_data,
   input  logic             pop,
   output u8d_pkg::job_type head,
   output logic             empty,
   output logic             full
);
   import u8d_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            do_push, do_pop;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CntW'(Depth));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CntW'(1);
         end
      end
   end

endmodule

@@ design/u8d_back.sv @@
// ----------------------------------------------------------------------------
// u8d_back: job expander and result register
// Expands the head job into its results, one per cycle whenever the result
// register is free or being popped; the consumer drains that register with pop.
// ----------------------------------------------------------------------------
module u8d_back (
   input  logic             clock,
   input  logic             reset,
   input  u8d_pkg::job_type head,
   input  logic             job_empty,
   output logic             job_pop,
   input  logic             pop,
   output logic             empty,
   output u8d_pkg::rsp_type rsp_data
);
   import u8d_pkg::*;

   logic [IDX_W-1:0] idx_ff;
   logic             valid_ff;
   rsp_type          rsp_ff, rsp_in;
   logic             emit;
   logic             last;

   assign empty    = !valid_ff;
   assign rsp_data = rsp_ff;
   assign emit     = !job_empty && (!valid_ff || pop);
   assign last     = ({1'b0, idx_ff} + CNT_W'(1)) == head.num_results;
   assign job_pop  = emit && last;

   always_comb begin
      rsp_in.code_point  = last ? head.last_cp : REPL_CP;
      rsp_in.malformed   = last ? head.last_mal : 1'b1;
      rsp_in.run_last    = last;
      rsp_in.stream_last = last && head.stream_end;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
         if (emit) begin
            idx_ff <= last ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

endmodule

@@ design/utf8_stream_decoder_core.sv @@
// The first result of a byte passes the job queue, then the result register, to rsp_data.
// One byte per cycle is taken while the job queue is not full; the k results of a byte hold
// the back end, one per cycle into the single result register while it is free or popped.
// The job queue (JobDepth entries) absorbs replacement bursts before push is refused.
// Reset is synchronous, active high: it closes any open sequence and empties
// the job queue and the result register.
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core: streaming UTF-8 to code point decoder
// Decodes one UTF-8 byte per transfer into Unicode code points, replacing
// malformed input with U+FFFD, one replacement per byte consumed.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core #(
   parameter int JobDepth = u8d_pkg::JOB_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  u8d_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output u8d_pkg::rsp_type rsp_data
);
   import u8d_pkg::*;

   // The front end owns the sequence state. Every accepted byte updates it
   // in the same cycle, and any results the byte causes are summarized in
   // one job record: a count, plus the code point and flag of the last
   // result. All earlier results of a byte are always replacements.
   logic    accept;
   logic    job_valid;
   job_type job;

   // Between the two halves sits a short job queue, so a burst of
   // replacements in the back end does not stop the byte stream at once.
   job_type head;
   logic    job_empty;
   logic    job_pop;

   assign accept = push && !full;

   u8d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job)
   );

   // Bytes that cause no result (a lead or a middle continuation) never
   // enter the queue, so full only reflects jobs still waiting.
   u8d_job_fifo #(
      .Depth (JobDepth)
   ) u_job_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_valid),
      .push_data (job),
      .pop       (job_pop),
      .head      (head),
      .empty     (job_empty),
      .full      (full)
   );

   // The back end walks the head job one result per cycle and writes each
   // into the result register whenever that register is free or being
   // drained in the same cycle, so results stream out back to back.
   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .job_empty (job_empty),
      .job_pop   (job_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/u8d_checker.sv @@
// ----------------------------------------------------------------------------
// u8d_checker: port-level checks of the UTF-8 stream decoder
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module u8d_checker (
   input logic             clock,
   input logic             reset,
   input logic             empty,
   input logic             pop,
   input u8d_pkg::rsp_type rsp_data
);
   import u8d_pkg::*;

   // Reset leaves no result waiting.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("result waiting right after reset");

   // A waiting result that is not taken stays as it is.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   // The final result of a stream is also the last one of its byte.
   a_stream_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.stream_last) |-> rsp_data.run_last)
      else $error("stream end flagged on a result that is not last of its byte");

   // A replacement always carries U+FFFD.
   a_repl: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.malformed) |-> (rsp_data.code_point == REPL_CP))
      else $error("malformed result without the replacement character");

   // A good result is a scalar value: in range and not a surrogate.
   a_scalar: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.malformed) |->
      ((rsp_data.code_point <= MAX_CP) &&
       ((rsp_data.code_point < SURR_LO) || (rsp_data.code_point > SURR_HI))))
      else $error("decoded code point out of range or a surrogate");

endmodule

bind utf8_stream_decoder_core u8d_checker u_checker (.*);
